FILE: design/delimited_frame_collector_assert.svh
// Assertion macros for the delimited frame collector.
`ifndef DELIMITED_FRAME_COLLECTOR_ASSERT_SVH
`define DELIMITED_FRAME_COLLECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DFC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DFC_ASSERT_IMPL(lbl, ante, cons)
`define DFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/dfc_pkg.sv
// Shared types and constants of the delimited frame collector.
package dfc_pkg;

    localparam int BYTE_W    = 8;
    localparam int OUT_LEN_W = 6;
    localparam int Q_DEPTH   = 4;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd33;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd42;

    localparam logic CFG_START_MARKER = 1'b0;
    localparam logic CFG_END_MARKER   = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_FAIL
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMIT,
        BK_TERM
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: design/delimited_frame_collector.sv
// Top level of the delimited frame collector: configuration, front, queue and back.
//
// Bytes between a start marker and an end marker are gathered into a message
// of up to BUFFER_DEPTH-1 bytes (the length wraps at BUFFER_DEPTH). A read
// request (mode 1) returns every stored byte and then a zero terminator with
// last set, or a single failure result when no complete message is pending.
// The front end takes one request per cycle while the four-entry command
// queue has room. The back end drains one store write per cycle while idle,
// gives a failure result once the output register is free, and streams a
// successful readout by taking the command, then emitting each byte through
// the registered store read, then the terminator, stretched by any stall on
// the output side.
module delimited_frame_collector
    import dfc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_got_message,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic [OUT_LEN_W-1:0] o_message_length,
    output logic                 o_last
);

`include "delimited_frame_collector_assert.svh"

    localparam int LW = $clog2(BUFFER_DEPTH);
    localparam int QW = $bits(t_op) + BYTE_W + LW;

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_end_marker;

    logic              in_accept;
    logic              q_push;
    t_op               q_op;
    logic [BYTE_W-1:0] q_data;
    logic [LW-1:0]     q_idx;
    logic [QW-1:0]     q_wdata;
    logic [QW-1:0]     q_rdata;
    logic              q_pop;
    t_q_status         q_st;
    t_op               b_op;
    logic [BYTE_W-1:0] b_data;
    logic [LW-1:0]     b_idx;

    // Configuration is always accepted; write the addressed marker.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default:          r_start_marker <= r_start_marker;
            endcase
        end
    end

    // Hold requests off only while the command queue is full.
    assign o_in_stall = q_st.full;
    assign in_accept  = i_in_valid && !q_st.full;

    dfc_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .LW           (LW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_mode         (i_mode),
        .i_rx_byte      (i_rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_push         (q_push),
        .o_op           (q_op),
        .o_data         (q_data),
        .o_idx          (q_idx)
    );

    // Pack the command: operation, byte, store index or message length.
    assign q_wdata = {q_op, q_data, q_idx};

    dfc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wdata),
        .i_pop    (q_pop),
        .o_data   (q_rdata),
        .o_status (q_st)
    );

    assign b_op   = t_op'(q_rdata[QW-1 -: $bits(t_op)]);
    assign b_data = q_rdata[LW +: BYTE_W];
    assign b_idx  = q_rdata[LW-1:0];

    dfc_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .LW           (LW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (!q_st.empty),
        .i_q_op           (b_op),
        .i_q_data         (b_data),
        .i_q_idx          (b_idx),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_got_message    (o_got_message),
        .o_out_byte       (o_out_byte),
        .o_message_length (o_message_length),
        .o_last           (o_last)
    );

    // A read command always carries a nonzero length.
    `DFC_ASSERT_IMPL(a_read_len_nonzero, q_push && (q_op == OP_READ), q_idx != '0)
    // Every accepted read request leaves a command in the queue.
    `DFC_ASSERT_IMPL(a_read_queued, in_accept && i_mode, q_push)
    // A pushed command is visible to the back end in the next cycle.
    `DFC_ASSERT_NEXT(a_push_visible, q_push, !q_st.empty)
    // A failure result is a lone zero result with last set.
    `DFC_ASSERT_IMPL(a_fail_shape, o_out_valid && !o_got_message,
                     o_last && (o_out_byte == '0) && (o_message_length == '0))

endmodule

FILE: design/dfc_front.sv
// Front end: tracks framing state and turns requests into queue commands.
module dfc_front
    import dfc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int LW           = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_mode,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [BYTE_W-1:0] i_start_marker,
    input  logic [BYTE_W-1:0] i_end_marker,
    output logic              o_push,
    output t_op               o_op,
    output logic [BYTE_W-1:0] o_data,
    output logic [LW-1:0]     o_idx
);

    logic          r_in_frame, n_in_frame;
    logic          r_ready,    n_ready;
    logic [LW-1:0] r_len,      n_len;
    logic [LW-1:0] len_inc;

    assign len_inc = (r_len == LW'(BUFFER_DEPTH - 1)) ? '0 : r_len + 1'b1;

    always_comb begin
        n_in_frame = r_in_frame;
        n_ready    = r_ready;
        n_len      = r_len;
        o_push     = 1'b0;
        o_op       = OP_FAIL;
        o_data     = i_rx_byte;
        o_idx      = r_len;
        if (i_accept) begin
            if (!i_mode) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == i_start_marker) begin
                        n_in_frame = 1'b1;
                        n_len      = '0;
                    end
                end else if (i_rx_byte == i_end_marker) begin
                    n_in_frame = 1'b0;
                    n_ready    = 1'b1;
                end else begin
                    // store at the current length, then advance with wrap
                    o_push = 1'b1;
                    o_op   = OP_WRITE;
                    n_len  = len_inc;
                end
            end else begin
                o_push = 1'b1;
                if (!r_in_frame && r_ready && (r_len != '0)) begin
                    o_op    = OP_READ;
                    n_len   = '0;
                    n_ready = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_ready    <= 1'b0;
            r_len      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_ready    <= n_ready;
            r_len      <= n_len;
        end
    end

endmodule

FILE: design/dfc_queue.sv
// Short command queue between the front and back ends.
module dfc_queue
    import dfc_pkg::*;
#(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_status    o_status
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [W-1:0]  r_entry [Q_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_data         = r_entry[r_rptr];
    assign o_status.full  = (r_count == CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/dfc_back.sv
// Back end: payload store, readout sequencer and output register.
module dfc_back
    import dfc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int LW           = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_op                  i_q_op,
    input  logic [BYTE_W-1:0]    i_q_data,
    input  logic [LW-1:0]        i_q_idx,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_got_message,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic [OUT_LEN_W-1:0] o_message_length,
    output logic                 o_last
);

    localparam int EW = LW + OUT_LEN_W;

    t_back_state r_state, n_state;

    logic [BYTE_W-1:0]    r_store [BUFFER_DEPTH];
    logic [BYTE_W-1:0]    r_rdata;
    logic [LW-1:0]        rd_addr;
    logic                 mem_we;

    logic [LW-1:0]        r_idx, n_idx;
    logic [LW-1:0]        r_len, n_len;
    logic [LW-1:0]        idx_inc;
    logic                 idx_last;
    logic [EW-1:0]        len_ext;

    logic                 r_out_valid, n_out_valid;
    logic                 r_got,  n_got;
    logic [BYTE_W-1:0]    r_byte, n_byte;
    logic [OUT_LEN_W-1:0] r_olen, n_olen;
    logic                 r_last, n_last;
    logic                 out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_inc  = r_idx + 1'b1;
    assign idx_last = (r_idx == r_len - 1'b1);
    assign len_ext  = EW'(r_len);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_out_valid = r_out_valid && i_out_stall;
        n_got       = r_got;
        n_byte      = r_byte;
        n_olen      = r_olen;
        n_last      = r_last;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        rd_addr     = r_idx;
        case (r_state)
            BK_IDLE: begin
                rd_addr = '0;
                if (i_q_valid) begin
                    case (i_q_op)
                        OP_WRITE: begin
                            o_q_pop = 1'b1;
                            mem_we  = 1'b1;
                        end
                        OP_READ: begin
                            o_q_pop = 1'b1;
                            n_len   = i_q_idx;
                            n_idx   = '0;
                            n_state = BK_EMIT;
                        end
                        default: begin
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_got       = 1'b0;
                                n_byte      = '0;
                                n_olen      = '0;
                                n_last      = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_got       = 1'b1;
                    n_byte      = r_rdata;
                    n_olen      = len_ext[OUT_LEN_W-1:0];
                    n_last      = 1'b0;
                    if (idx_last) begin
                        n_state = BK_TERM;
                    end else begin
                        n_idx   = idx_inc;
                        rd_addr = idx_inc;
                    end
                end
            end
            BK_TERM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_got       = 1'b1;
                    n_byte      = '0;
                    n_olen      = len_ext[OUT_LEN_W-1:0];
                    n_last      = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[i_q_idx] <= i_q_data;
        end
        r_rdata <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_len  <= n_len;
        r_got  <= n_got;
        r_byte <= n_byte;
        r_olen <= n_olen;
        r_last <= n_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_got_message    = r_got;
    assign o_out_byte       = r_byte;
    assign o_message_length = r_olen;
    assign o_last           = r_last;

endmodule
